// ===== rtl/nv21_to_argb_rotate90_assert.svh =====
// assertion helpers for the rtl files, included by n2argb_back
`ifndef NV21_TO_ARGB_ROTATE90_ASSERT_SVH
`define NV21_TO_ARGB_ROTATE90_ASSERT_SVH

// property must hold at every clock edge outside reset
`define N2A_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition must never be seen outside reset
`define N2A_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== rtl/n2argb_pkg.sv =====
// ----------------------------------------------------------------------------
// n2argb_pkg
// Shared types, register indexes and constants of the nv21 to argb converter.
// ----------------------------------------------------------------------------
package n2argb_pkg;

    localparam int CFG_DATA_W  = 13;
    localparam int CFG_INDEX_W = 1;
    localparam int POS_W       = 13;
    localparam int OUT_INDEX_W = 24;
    localparam int PROD_W      = 20;
    localparam int TERM_W      = 10;
    localparam int SUM_W       = 12;
    localparam int MID_DEPTH   = 4;
    localparam int OUT_DEPTH   = 4;

    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

    localparam logic [CFG_DATA_W-1:0] WIDTH_RESET  = 13'd640;
    localparam logic [CFG_DATA_W-1:0] HEIGHT_RESET = 13'd480;
    localparam logic [7:0]            CHROMA_RESET = 8'd128;
    localparam logic [7:0]            ALPHA_OPAQUE = 8'hFF;

    // q10 coefficients
    localparam logic signed [PROD_W-1:0] COEF_R_CR = 20'sd1434;
    localparam logic signed [PROD_W-1:0] COEF_G_CB = 20'sd352;
    localparam logic signed [PROD_W-1:0] COEF_G_CR = 20'sd731;
    localparam logic signed [PROD_W-1:0] COEF_B_CB = 20'sd1812;
    localparam logic signed [PROD_W-1:0] Q10_BIAS  = 20'sd1023;

    typedef struct packed {
        logic [7:0] luma;
        logic [7:0] chroma_first;
        logic [7:0] chroma_second;
    } pixel_t;

    typedef struct packed {
        logic [31:0]            pixel_argb;
        logic [OUT_INDEX_W-1:0] out_index;
        logic                   frame_end;
    } result_t;

    // classified request handed from front to back
    typedef struct packed {
        logic [7:0]       luma;
        logic [7:0]       chroma_first;
        logic [7:0]       chroma_second;
        logic [POS_W-1:0] col;
        logic [POS_W-1:0] row;
        logic             last;
    } mid_t;

    // truncate toward zero after dropping ten fraction bits
    function automatic logic signed [TERM_W-1:0] q10_trunc(input logic signed [PROD_W-1:0] x);
        logic signed [PROD_W-1:0] biased;
        biased = x + (x[PROD_W-1] ? Q10_BIAS : '0);
        return biased[PROD_W-1 -: TERM_W];
    endfunction

    function automatic logic [7:0] clamp_channel(input logic signed [SUM_W-1:0] v);
        logic [7:0] res;
        if (v < 0)
        begin
            res = 8'd0;
        end
        else if (v > 12'sd255)
        begin
            res = 8'd255;
        end
        else
        begin
            res = v[7:0];
        end
        return res;
    endfunction

endpackage

// ===== rtl/nv21_to_argb_rotate90.sv =====
// ----------------------------------------------------------------------------
// nv21_to_argb_rotate90
// NV21 pixel stream to opaque ARGB with a 90 degree clockwise destination index.
// ----------------------------------------------------------------------------
// Takes one pixel per clock and returns one ARGB result per clock when the
// result side pops every cycle. A pushed pixel goes into the request queue,
// through two pipeline stages for the color products and the rotated index,
// then into the result queue. The result queue has four entries, enough
// credit to cover the two pipeline stages, so pop stalls back up into the
// request queue and then to full without dropping anything. Frame width and
// height are written through the cfg port, which is always ready; write them
// only while no pixel is in flight.
module nv21_to_argb_rotate90 import n2argb_pkg::*; #(
    parameter int MAX_DIMENSION = 4096
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  pixel_t                 pixel,
    output logic                   full,
    input  logic                   pop,
    output result_t                result,
    output logic                   empty,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int DIM_W = $clog2(MAX_DIMENSION + 1);

    logic             mid_push, mid_pop, mid_full, mid_empty;
    mid_t             mid_wr, mid_rd;
    logic [DIM_W-1:0] height;

    assign cfg_ready = 1'b1;
    assign full      = mid_full;

    n2argb_front #(
        .MAX_DIMENSION (MAX_DIMENSION)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .pixel     (pixel),
        .mid_full  (mid_full),
        .mid_push  (mid_push),
        .mid_item  (mid_wr),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .height    (height)
    );

    n2argb_fifo #(
        .WIDTH ($bits(mid_t)),
        .DEPTH (MID_DEPTH)
    ) u_mid_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (mid_push),
        .wdata (mid_wr),
        .full  (mid_full),
        .pop   (mid_pop),
        .rdata (mid_rd),
        .empty (mid_empty)
    );

    n2argb_back #(
        .MAX_DIMENSION (MAX_DIMENSION)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .mid_empty (mid_empty),
        .mid_item  (mid_rd),
        .mid_pop   (mid_pop),
        .height    (height),
        .pop       (pop),
        .result    (result),
        .empty     (empty)
    );

endmodule

// ===== rtl/n2argb_fifo.sv =====
// ----------------------------------------------------------------------------
// n2argb_fifo
// Small register queue with full and empty flags.
// ----------------------------------------------------------------------------
module n2argb_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

// ===== rtl/n2argb_front.sv =====
// ----------------------------------------------------------------------------
// n2argb_front
// Frame size registers, raster position tracking and chroma pair latching.
// ----------------------------------------------------------------------------
module n2argb_front import n2argb_pkg::*; #(
    parameter int MAX_DIMENSION = 4096
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   push,
    input  pixel_t                                 pixel,
    input  logic                                   mid_full,
    output logic                                   mid_push,
    output mid_t                                   mid_item,
    input  logic                                   cfg_valid,
    input  logic [CFG_INDEX_W-1:0]                 cfg_index,
    input  logic [CFG_DATA_W-1:0]                  cfg_data,
    output logic [$clog2(MAX_DIMENSION + 1)-1:0]   height
);

    localparam int CNT_W = $clog2(MAX_DIMENSION);
    localparam int DIM_W = $clog2(MAX_DIMENSION + 1);

    logic [CFG_DATA_W-1:0] width_reg, height_reg;
    logic [CNT_W-1:0]      col_reg, col_next;
    logic [CNT_W-1:0]      row_reg, row_next;
    logic [7:0]            held_first_reg, held_second_reg;
    logic [DIM_W-1:0]      width_use;
    logic [CNT_W-1:0]      col_cur, row_cur;
    logic [7:0]            cr_use, cb_use;
    logic                  accept, last;

    function automatic logic [DIM_W-1:0] clamp_size(input logic [CFG_DATA_W-1:0] v);
        logic [DIM_W-1:0] res;
        if (v < CFG_DATA_W'(2))
        begin
            res = DIM_W'(2);
        end
        else if (32'(v) > 32'(MAX_DIMENSION))
        begin
            res = DIM_W'(MAX_DIMENSION);
        end
        else
        begin
            res = DIM_W'(v);
        end
        return res;
    endfunction

    assign width_use = clamp_size(width_reg);
    assign height    = clamp_size(height_reg);
    assign accept    = push && !mid_full;
    assign mid_push  = accept;

    // a size change between frames can leave the position past the new bounds
    always_comb
    begin
        logic [31:0] row_tmp;
        logic [31:0] col_inc;
        logic [31:0] row_inc;
        row_tmp = 32'(row_reg);
        col_cur = col_reg;
        if (32'(col_reg) >= 32'(width_use))
        begin
            col_cur = '0;
            row_tmp = 32'(row_reg) + 32'd1;
        end
        row_cur = (row_tmp >= 32'(height)) ? '0 : CNT_W'(row_tmp);

        last = (32'(col_cur) == 32'(width_use) - 32'd1)
            && (32'(row_cur) == 32'(height) - 32'd1);

        col_inc  = 32'(col_cur) + 32'd1;
        row_inc  = 32'(row_cur) + 32'd1;
        col_next = CNT_W'(col_inc);
        row_next = row_cur;
        if (col_inc >= 32'(width_use))
        begin
            col_next = '0;
            row_next = (row_inc >= 32'(height)) ? '0 : CNT_W'(row_inc);
        end
    end

    assign cr_use = col_cur[0] ? held_first_reg  : pixel.chroma_first;
    assign cb_use = col_cur[0] ? held_second_reg : pixel.chroma_second;

    always_comb
    begin
        mid_item.luma          = pixel.luma;
        mid_item.chroma_first  = cr_use;
        mid_item.chroma_second = cb_use;
        mid_item.col           = POS_W'(col_cur);
        mid_item.row           = POS_W'(row_cur);
        mid_item.last          = last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg       <= WIDTH_RESET;
            height_reg      <= HEIGHT_RESET;
            col_reg         <= '0;
            row_reg         <= '0;
            held_first_reg  <= CHROMA_RESET;
            held_second_reg <= CHROMA_RESET;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    REG_FRAME_WIDTH:  width_reg  <= cfg_data;
                    REG_FRAME_HEIGHT: height_reg <= cfg_data;
                    default:          width_reg  <= width_reg;
                endcase
            end
            if (accept)
            begin
                col_reg         <= col_next;
                row_reg         <= row_next;
                held_first_reg  <= cr_use;
                held_second_reg <= cb_use;
            end
        end
    end

endmodule

// ===== rtl/n2argb_back.sv =====
// ----------------------------------------------------------------------------
// n2argb_back
// Color math pipeline, rotated index and result queue with credit control.
// ----------------------------------------------------------------------------
module n2argb_back import n2argb_pkg::*; #(
    parameter int MAX_DIMENSION = 4096
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 mid_empty,
    input  mid_t                                 mid_item,
    output logic                                 mid_pop,
    input  logic [$clog2(MAX_DIMENSION + 1)-1:0] height,
    input  logic                                 pop,
    output result_t                              result,
    output logic                                 empty
);

    `include "nv21_to_argb_rotate90_assert.svh"

    localparam int DIM_W  = $clog2(MAX_DIMENSION + 1);
    localparam int IDXP_W = DIM_W + POS_W;
    localparam int CR_W   = $clog2(OUT_DEPTH + 1);

    logic [CR_W-1:0] inflight_reg, inflight_next;
    logic            out_push, out_full, out_pop;

    // stage one: products, scaled luma and index parts
    logic                     s1_valid_reg;
    logic [8:0]               s1_ys_reg;
    logic signed [PROD_W-1:0] s1_r_reg, s1_ga_reg, s1_gb_reg, s1_b_reg;
    logic [IDXP_W-1:0]        s1_idx_reg;
    logic [DIM_W-1:0]         s1_off_reg;
    logic                     s1_last_reg;

    // stage two: truncated terms and index
    logic                     s2_valid_reg;
    logic [8:0]               s2_ys_reg;
    logic signed [TERM_W-1:0] s2_r_reg, s2_g_reg, s2_b_reg;
    logic [OUT_INDEX_W-1:0]   s2_idx_reg;
    logic                     s2_last_reg;

    logic signed [7:0]        c1, c2;
    logic signed [PROD_W-1:0] c1_ext, c2_ext;
    logic [7:0]               y;
    logic [8:0]               ys;
    logic signed [SUM_W-1:0]  ys_ext, r_sum, g_sum, b_sum;
    result_t                  out_item;

    assign out_pop = pop && !empty;
    assign mid_pop = !mid_empty && (inflight_reg < CR_W'(OUT_DEPTH));
    assign out_push = s2_valid_reg;

    always_comb
    begin
        inflight_next = inflight_reg;
        if (mid_pop && !out_pop)
        begin
            inflight_next = inflight_reg + CR_W'(1);
        end
        else if (out_pop && !mid_pop)
        begin
            inflight_next = inflight_reg - CR_W'(1);
        end
    end

    // byte minus 128 is the byte with its top bit flipped
    assign c1     = {~mid_item.chroma_first[7], mid_item.chroma_first[6:0]};
    assign c2     = {~mid_item.chroma_second[7], mid_item.chroma_second[6:0]};
    assign c1_ext = PROD_W'(c1);
    assign c2_ext = PROD_W'(c2);
    assign y      = mid_item.luma;
    assign ys     = 9'(y) + 9'(y >> 3) + 9'(y >> 5) + 9'(y >> 7);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inflight_reg <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            inflight_reg <= inflight_next;
            s1_valid_reg <= mid_pop;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_ys_reg   <= ys;
        s1_r_reg    <= c1_ext * COEF_R_CR;
        s1_ga_reg   <= c2_ext * COEF_G_CB;
        s1_gb_reg   <= c1_ext * COEF_G_CR;
        s1_b_reg    <= c2_ext * COEF_B_CB;
        s1_idx_reg  <= IDXP_W'(height) * IDXP_W'(mid_item.col);
        s1_off_reg  <= height - DIM_W'(1) - DIM_W'(mid_item.row);
        s1_last_reg <= mid_item.last;

        s2_ys_reg   <= s1_ys_reg;
        s2_r_reg    <= q10_trunc(s1_r_reg);
        s2_g_reg    <= q10_trunc(s1_ga_reg + s1_gb_reg);
        s2_b_reg    <= q10_trunc(s1_b_reg);
        s2_idx_reg  <= OUT_INDEX_W'(32'(s1_idx_reg) + 32'(s1_off_reg));
        s2_last_reg <= s1_last_reg;
    end

    assign ys_ext = $signed({3'b000, s2_ys_reg});
    assign r_sum  = ys_ext + SUM_W'(s2_r_reg);
    assign g_sum  = ys_ext - SUM_W'(s2_g_reg);
    assign b_sum  = ys_ext + SUM_W'(s2_b_reg);

    always_comb
    begin
        out_item.pixel_argb = {ALPHA_OPAQUE, clamp_channel(r_sum),
                               clamp_channel(g_sum), clamp_channel(b_sum)};
        out_item.out_index  = s2_idx_reg;
        out_item.frame_end  = s2_last_reg;
    end

    n2argb_fifo #(
        .WIDTH ($bits(result_t)),
        .DEPTH (OUT_DEPTH)
    ) u_out_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (out_push),
        .wdata (out_item),
        .full  (out_full),
        .pop   (pop),
        .rdata (result),
        .empty (empty)
    );

    // credits reserve a queue slot for every request in the pipeline
    `N2A_NEVER(a_out_overflow, out_push && out_full, "result queue written while full")
    `N2A_ASSERT(a_credit_bound, inflight_reg <= CR_W'(OUT_DEPTH), "credit count above queue depth")
    `N2A_ASSERT(a_issue_flows, mid_pop |=> s1_valid_reg ##1 s2_valid_reg, "issued request lost in pipeline")

endmodule

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Checks the nv21 to argb converter against its own predictor, pixel by pixel.
// Pixels are fed through push/full, results drained through empty/pop with
// random gaps and stalls on both sides, frame sizes rewritten between phases.
// ----------------------------------------------------------------------------
module testbench import n2argb_pkg::*; ();

    localparam int MAX_DIM     = 4096;
    localparam int CYCLE_LIMIT = 400000;
    localparam int RAND_ITEMS  = 900;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   push      = 1'b0;
    pixel_t                 pixel     = '0;
    logic                   full;
    logic                   pop       = 1'b0;
    result_t                result;
    logic                   empty;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = REG_FRAME_WIDTH;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    pixel_t  pending_pixels[$];
    result_t expected_results[$];

    // predictor copy of the registers and the stream position
    logic [CFG_DATA_W-1:0] reg_width  = WIDTH_RESET;
    logic [CFG_DATA_W-1:0] reg_height = HEIGHT_RESET;
    int col_count  = 0;
    int row_count  = 0;
    int held_cr    = 128;
    int held_cb    = 128;

    int send_max_gap = 8;
    int recv_max_gap = 8;
    int send_wait    = 0;
    int recv_wait    = 0;
    int stall_draw;
    int fail_count   = 0;
    int cycle_count  = 0;
    result_t want_res;

    int fixed_w[8] = '{3, 16, 8191, 2, 4096, 6, 1, 10};
    int fixed_h[8] = '{5, 8, 4096, 4096, 2, 3, 0, 12};

    nv21_to_argb_rotate90 #(
        .MAX_DIMENSION(MAX_DIM)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .pixel     (pixel),
        .full      (full),
        .pop       (pop),
        .result    (result),
        .empty     (empty),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic int clip_byte(input int v);
        int res;
        if (v < 0)
        begin
            res = 0;
        end
        else if (v > 255)
        begin
            res = 255;
        end
        else
        begin
            res = v;
        end
        return res;
    endfunction

    function automatic int clip_dim(input logic [CFG_DATA_W-1:0] v);
        int res;
        if (v < 2)
        begin
            res = 2;
        end
        else if (v > MAX_DIM)
        begin
            res = MAX_DIM;
        end
        else
        begin
            res = int'(v);
        end
        return res;
    endfunction

    // expected argb pixel and rotated index for one accepted request
    task automatic predict_pixel(input pixel_t px);
        int w, h, col, row, ys, c1, c2, r, g, b, idx;
        result_t res;
        w = clip_dim(reg_width);
        h = clip_dim(reg_height);
        // a shrunk size can leave the counters past the end
        if (col_count >= w)
        begin
            col_count = 0;
            row_count++;
        end
        if (row_count >= h)
        begin
            row_count = 0;
        end
        col = col_count;
        row = row_count;
        if (col[0] == 1'b0)
        begin
            held_cr = int'(px.chroma_first);
            held_cb = int'(px.chroma_second);
        end
        ys = int'(px.luma);
        ys = ys + (ys >> 3) + (ys >> 5) + (ys >> 7);
        c1 = held_cr - 128;
        c2 = held_cb - 128;
        r = clip_byte(ys + (1434 * c1) / 1024);
        g = clip_byte(ys - (352 * c2 + 731 * c1) / 1024);
        b = clip_byte(ys + (1812 * c2) / 1024);
        idx = h * col + (h - 1 - row);
        res.pixel_argb = {ALPHA_OPAQUE, r[7:0], g[7:0], b[7:0]};
        res.out_index  = idx[OUT_INDEX_W-1:0];
        res.frame_end  = (col == w - 1) && (row == h - 1);
        expected_results.push_back(res);
        col_count = col + 1;
        if (col_count >= w)
        begin
            col_count = 0;
            row_count = row + 1;
            if (row_count >= h)
            begin
                row_count = 0;
            end
        end
    endtask

    // sender: one request per pending pixel, random gap after each
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            push      <= 1'b0;
            send_wait <= 0;
        end
        else
        begin
            if (push && !full)
            begin
                predict_pixel(pixel);
            end
            if (!push || !full)
            begin
                if (send_wait != 0)
                begin
                    push      <= 1'b0;
                    send_wait <= send_wait - 1;
                end
                else if (pending_pixels.size() != 0)
                begin
                    push      <= 1'b1;
                    pixel     <= pending_pixels.pop_front();
                    send_wait <= $urandom_range(0, send_max_gap);
                end
                else
                begin
                    push <= 1'b0;
                end
            end
        end
    end

    // receiver: compare each popped result with the oldest expectation
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pop       <= 1'b0;
            recv_wait <= 0;
        end
        else if (pop && !empty)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t unexpected result: actual %h", $time, result);
                fail_count++;
            end
            else
            begin
                want_res = expected_results.pop_front();
                if (result.pixel_argb !== want_res.pixel_argb)
                begin
                    $display("%0t pixel_argb: expected %h, actual %h",
                             $time, want_res.pixel_argb, result.pixel_argb);
                    fail_count++;
                end
                if (result.out_index !== want_res.out_index)
                begin
                    $display("%0t out_index: expected %0d, actual %0d",
                             $time, want_res.out_index, result.out_index);
                    fail_count++;
                end
                if (result.frame_end !== want_res.frame_end)
                begin
                    $display("%0t frame_end: expected %b, actual %b",
                             $time, want_res.frame_end, result.frame_end);
                    fail_count++;
                end
            end
            stall_draw = $urandom_range(0, recv_max_gap);
            recv_wait <= stall_draw;
            pop       <= (stall_draw == 0);
        end
        else if (recv_wait != 0)
        begin
            recv_wait <= recv_wait - 1;
            pop       <= (recv_wait == 1);
        end
        else
        begin
            pop <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        cfg_valid <= 1'b0;
        if (idx == REG_FRAME_WIDTH)
        begin
            reg_width = val;
        end
        else
        begin
            reg_height = val;
        end
    endtask

    task automatic wait_drained();
        while (pending_pixels.size() != 0 || push || expected_results.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    function automatic logic [7:0] rand_byte();
        logic [7:0] v;
        case ($urandom_range(0, 7))
            0: v = 8'd0;
            1: v = 8'd255;
            2: v = 8'd128;
            default: v = 8'($urandom_range(0, 255));
        endcase
        return v;
    endfunction

    task automatic queue_random_pixels(input int n);
        pixel_t px;
        for (int i = 0; i < n; i++)
        begin
            px.luma          = rand_byte();
            px.chroma_first  = rand_byte();
            px.chroma_second = rand_byte();
            pending_pixels.push_back(px);
        end
    endtask

    function automatic int rand_dim();
        int v;
        case ($urandom_range(0, 3))
            0: v = 2 * $urandom_range(1, 8);
            1: v = 2 * $urandom_range(1, 8) + 1;
            2: v = $urandom_range(2, 64);
            default: v = $urandom_range(2, 8);
        endcase
        return v;
    endfunction

    initial
    begin
        int phase;
        int n;
        int w;
        int h;
        int rand_total;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // reset sizes: extremes, odd columns carry chroma that must be ignored
        pending_pixels.push_back(pixel_t'{8'd0,   8'd0,   8'd0});
        pending_pixels.push_back(pixel_t'{8'd255, 8'hAA, 8'h55});
        pending_pixels.push_back(pixel_t'{8'd255, 8'd255, 8'd255});
        pending_pixels.push_back(pixel_t'{8'd0,   8'd0,   8'd255});
        pending_pixels.push_back(pixel_t'{8'd128, 8'd128, 8'd128});
        pending_pixels.push_back(pixel_t'{8'd255, 8'd0,   8'd255});
        pending_pixels.push_back(pixel_t'{8'd0,   8'd255, 8'd0});
        pending_pixels.push_back(pixel_t'{8'd255, 8'd255, 8'd0});
        wait_drained();

        // smallest frame, counters left past the new width
        write_reg(REG_FRAME_WIDTH, 13'd2);
        write_reg(REG_FRAME_HEIGHT, 13'd2);
        pending_pixels.push_back(pixel_t'{8'd16,  8'd240, 8'd16});
        pending_pixels.push_back(pixel_t'{8'd235, 8'd0,   8'd0});
        pending_pixels.push_back(pixel_t'{8'd1,   8'd127, 8'd129});
        pending_pixels.push_back(pixel_t'{8'd254, 8'd1,   8'd254});
        pending_pixels.push_back(pixel_t'{8'd255, 8'd255, 8'd255});
        pending_pixels.push_back(pixel_t'{8'd0,   8'd0,   8'd0});
        pending_pixels.push_back(pixel_t'{8'd200, 8'd60,  8'd200});
        pending_pixels.push_back(pixel_t'{8'd50,  8'd200, 8'd60});
        wait_drained();

        // sizes below range clamp up to two
        write_reg(REG_FRAME_WIDTH, 13'd0);
        write_reg(REG_FRAME_HEIGHT, 13'd1);
        queue_random_pixels(6);
        wait_drained();

        rand_total = 0;
        phase = 0;
        while (rand_total < RAND_ITEMS)
        begin
            if (phase < 8)
            begin
                w = fixed_w[phase];
                h = fixed_h[phase];
            end
            else
            begin
                w = rand_dim();
                h = rand_dim();
            end
            write_reg(REG_FRAME_WIDTH, CFG_DATA_W'(w));
            if (phase % 6 != 5)
            begin
                write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'(h));
            end
            case (phase % 3)
                0:
                begin
                    send_max_gap = 8;
                    recv_max_gap = 8;
                end
                1:
                begin
                    send_max_gap = 0;
                    recv_max_gap = 8;
                end
                default:
                begin
                    send_max_gap = 8;
                    recv_max_gap = 0;
                end
            endcase
            if (phase % 5 == 4)
            begin
                send_max_gap = 0;
                recv_max_gap = 0;
            end
            if (clip_dim(reg_width) > 64 || clip_dim(reg_height) > 64)
            begin
                n = 25;
            end
            else
            begin
                n = $urandom_range(40, 80);
            end
            if (phase % 4 == 1)
            begin
                // sender holds off until every result so far is back
                queue_random_pixels(n / 2);
                wait_drained();
                queue_random_pixels(n - n / 2);
            end
            else
            begin
                queue_random_pixels(n);
            end
            wait_drained();
            rand_total += n;
            phase++;
        end

        wait_drained();
        repeat (16) @(posedge clk);
        if (fail_count == 0 && expected_results.size() == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
